// ===== sv/rfc_pkg.sv =====
package rfc_pkg;

  localparam int STORE_WORDS_DEF = 4096;
  localparam int COORD_BITS_DEF  = 6;

  localparam int WORD_W      = 32;
  localparam int INDEX_W     = 20;
  localparam int CFG_W       = 7;
  localparam int CFG_IDX_W   = 2;
  localparam int LOAD_ADDR_W = 12;
  localparam int KIND_W      = 2;
  localparam int STATUS_W    = 2;

  localparam logic [KIND_W-1:0] KIND_LOAD = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ROI  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ADV  = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NO_ROI = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_REJECT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS   = 2'd2;

  localparam logic [CFG_W-1:0] MAP_WIDTH_RST  = 7'd64;
  localparam logic [CFG_W-1:0] MAP_HEIGHT_RST = 7'd64;
  localparam logic [CFG_W-1:0] CHANNELS_RST   = 7'd1;

endpackage

// ===== sv/rfc_store.sv =====
module rfc_store import rfc_pkg::*; #(
  parameter int STORE_WORDS = STORE_WORDS_DEF
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic                           we,
  input  logic [$clog2(STORE_WORDS)-1:0] addr,
  input  logic [WORD_W-1:0]              wdata,
  output logic [WORD_W-1:0]              rdata
);

  logic [WORD_W-1:0] mem [STORE_WORDS];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ===== sv/rfc_addr_gen.sv =====
// word address = ch * (width * height) + row * width + col, three register stages
module rfc_addr_gen import rfc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [COORD_BITS-1:0]         ch,
  input  logic [COORD_BITS:0]           row,
  input  logic [COORD_BITS:0]           col,
  input  logic [CFG_W-1:0]              map_width,
  input  logic [CFG_W-1:0]              map_height,
  output logic                          done,
  output logic [COORD_BITS+2*CFG_W:0]   raw
);

  localparam int AREA_W = 2 * CFG_W;
  localparam int RW_W   = COORD_BITS + 1 + CFG_W;
  localparam int RWC_W  = RW_W + 1;
  localparam int PR_W   = COORD_BITS + AREA_W;
  localparam int RAW_W  = COORD_BITS + 2 * CFG_W + 1;

  logic [AREA_W-1:0]     area_q;
  logic [RW_W-1:0]       rw_q;
  logic [COORD_BITS-1:0] ch_q;
  logic [COORD_BITS:0]   col_q;
  logic [PR_W-1:0]       prod_q;
  logic [RWC_W-1:0]      rwc_q;
  logic [RAW_W-1:0]      raw_q;
  logic [2:0]            vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[1:0], start};
    end
  end

  always_ff @(posedge clk) begin
    area_q <= AREA_W'(map_width) * AREA_W'(map_height);
    rw_q   <= RW_W'(row) * RW_W'(map_width);
    ch_q   <= ch;
    col_q  <= col;
    prod_q <= PR_W'(ch_q) * PR_W'(area_q);
    rwc_q  <= RWC_W'(rw_q) + RWC_W'(col_q);
    raw_q  <= RAW_W'(prod_q) + RAW_W'(rwc_q);
  end

  assign done = vld[2];
  assign raw  = raw_q;

endmodule

// ===== sv/rfc_mod_unit.sv =====
// Reduces a raw address modulo the store depth. Power-of-two depth: truncation
// of the registered value. Otherwise multiply by a scaled reciprocal for the
// quotient, multiply back and subtract, with each product registered.
module rfc_mod_unit import rfc_pkg::*; #(
  parameter int STORE_WORDS = STORE_WORDS_DEF,
  parameter int RAW_W       = COORD_BITS_DEF + 2 * CFG_W + 1
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [RAW_W-1:0]               raw,
  output logic                           done,
  output logic [$clog2(STORE_WORDS)-1:0] rem
);

  localparam int AW      = $clog2(STORE_WORDS);
  localparam bit IS_POW2 = ((STORE_WORDS & (STORE_WORDS - 1)) == 0);
  // with RECIP = ceil(2^SH / depth), (raw * RECIP) >> SH is the exact quotient
  // for every raw below 2^RAW_W
  localparam int SH      = RAW_W + AW;
  localparam int RECIP_W = RAW_W + 1;
  localparam int PROD_W  = RAW_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << SH) + 64'(STORE_WORDS) - 64'd1) / 64'(STORE_WORDS));

  logic [RAW_W-1:0]  x1;
  logic [RAW_W-1:0]  x2;
  logic [PROD_W-1:0] prod;
  logic [RAW_W-1:0]  back;
  logic [RAW_W-1:0]  r;
  logic [2:0]        vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[1:0], start};
    end
  end

  always_ff @(posedge clk) begin
    x1   <= raw;
    prod <= PROD_W'(raw) * PROD_W'(RECIP);
    x2   <= x1;
    back <= RAW_W'(prod[PROD_W-1:SH]) * RAW_W'(STORE_WORDS);
    if (IS_POW2) begin
      if (start) begin
        r <= raw;
      end
    end else if (vld[1]) begin
      r <= x2 - back;
    end
  end

  assign done = IS_POW2 ? vld[0] : vld[2];
  assign rem  = r[AW-1:0];

endmodule

// ===== sv/roi_feature_crop.sv =====
// ROI crop engine over a word store of STORE_WORDS x 32 bits. Items are
// handled one at a time; the store address (channel * area + row * width
// + col) is built in a three-stage multiply pipeline and then reduced modulo
// the store depth, and the store is a single-port synchronous RAM with a
// registered read. A load is reduced and then written; a ROI item only runs
// the address pipeline, to check its last word; an advance under an accepted
// ROI runs the pipeline, the reduction and a store read, while one answering
// "no ROI" or "rejected" goes straight to the output register.
// The output register lets the next item be taken while a result waits.
// The store has no reset and needs no clearing pass: entries must be loaded
// before an ROI reads them.
module roi_feature_crop import rfc_pkg::*; #(
  parameter int STORE_WORDS = STORE_WORDS_DEF,
  parameter int COORD_BITS  = COORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // load_address, load_value, x_left, y_bottom, x_right, y_top, first_roi
  input  logic [(LOAD_ADDR_W+WORD_W+4*COORD_BITS+1+7)/8*8-1:0] s_tdata,
  // kind
  input  logic [KIND_W-1:0]    s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // value, dest_index
  output logic [(WORD_W+INDEX_W+7)/8*8-1:0] m_tdata,
  // status
  output logic [STATUS_W-1:0]  m_tuser,
  // last_of_roi
  output logic                 m_tlast
);

  localparam int AW        = $clog2(STORE_WORDS);
  localparam int RAW_W     = COORD_BITS + 2 * CFG_W + 1;
  localparam int CMP_W     = COORD_BITS + CFG_W + 1;
  localparam int OUT_PAD   = (WORD_W + INDEX_W + 7) / 8 * 8 - WORD_W - INDEX_W;
  localparam int VAL_LSB   = LOAD_ADDR_W;
  localparam int XL_LSB    = LOAD_ADDR_W + WORD_W;
  localparam int YB_LSB    = XL_LSB + COORD_BITS;
  localparam int XR_LSB    = YB_LSB + COORD_BITS;
  localparam int YT_LSB    = XR_LSB + COORD_BITS;
  localparam int FIRST_LSB = YT_LSB + COORD_BITS;
  localparam logic [CMP_W-1:0] CH_LIMIT = CMP_W'(1) << COORD_BITS;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_GEN  = 2'd1;
  localparam logic [1:0] S_MOD  = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  // configuration
  logic [CFG_W-1:0] map_width;
  logic [CFG_W-1:0] map_height;
  logic [CFG_W-1:0] channel_count;

  // crop state
  logic [COORD_BITS-1:0] roi_xl, roi_yb, roi_xr, roi_yt;
  logic [COORD_BITS-1:0] ch_cnt, row_cnt, col_cnt;
  logic [INDEX_W-1:0]    out_idx;
  logic                  roi_active;
  logic                  roi_rejected;

  // captured item
  logic [KIND_W-1:0]     item_kind;
  logic [WORD_W-1:0]     item_value;
  logic [COORD_BITS-1:0] item_xl, item_yb, item_xr, item_yt;
  logic                  item_first;
  logic [STATUS_W-1:0]   item_status;

  // output register
  logic [WORD_W-1:0]   out_value;
  logic [INDEX_W-1:0]  out_index;
  logic                out_last;
  logic [STATUS_W-1:0] out_status;

  logic                  accept;
  logic [KIND_W-1:0]     in_kind;
  logic [COORD_BITS-1:0] in_xl, in_yb, in_xr, in_yt;
  logic                  crop_ok;

  logic [COORD_BITS:0]   col_sum, row_sum;
  logic                  col_end, row_end, ch_end, adv_last;
  logic [CFG_W-1:0]      ch_minus;

  logic                  gen_start, gen_done;
  logic [COORD_BITS-1:0] gen_ch;
  logic [COORD_BITS:0]   gen_row, gen_col;
  logic [RAW_W-1:0]      gen_raw;

  logic                  mod_start, mod_done;
  logic [RAW_W-1:0]      mod_raw;
  logic [AW-1:0]         mod_rem;

  logic                  mem_en, mem_we;
  logic [WORD_W-1:0]     rd_data;

  logic                  roi_commit, roi_bad, emit_fire;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign in_kind  = s_tuser;
  assign in_xl    = s_tdata[XL_LSB +: COORD_BITS];
  assign in_yb    = s_tdata[YB_LSB +: COORD_BITS];
  assign in_xr    = s_tdata[XR_LSB +: COORD_BITS];
  assign in_yt    = s_tdata[YT_LSB +: COORD_BITS];
  assign crop_ok  = roi_active && !roi_rejected;

  // position of the next word inside the map
  assign col_sum  = {1'b0, roi_xl} + {1'b0, col_cnt};
  assign row_sum  = {1'b0, roi_yb} + {1'b0, row_cnt};
  assign col_end  = col_sum >= {1'b0, roi_xr};
  assign row_end  = row_sum >= {1'b0, roi_yt};
  assign ch_end   = (CMP_W'(ch_cnt) + CMP_W'(1)) >= CMP_W'(channel_count);
  assign adv_last = col_end && row_end && ch_end;

  // a ROI item checks the address of its last word; an advance its own word
  assign ch_minus  = channel_count - CFG_W'(1);
  assign gen_ch    = (in_kind == KIND_ROI) ? COORD_BITS'(ch_minus) : ch_cnt;
  assign gen_row   = (in_kind == KIND_ROI) ? {1'b0, in_yt} : row_sum;
  assign gen_col   = (in_kind == KIND_ROI) ? {1'b0, in_xr} : col_sum;
  assign gen_start = accept && ((in_kind == KIND_ROI) || ((in_kind == KIND_ADV) && crop_ok));

  assign mod_raw   = (state == S_IDLE) ? RAW_W'(s_tdata[LOAD_ADDR_W-1:0]) : gen_raw;
  assign mod_start = (accept && (in_kind == KIND_LOAD))
                  || ((state == S_GEN) && gen_done && (item_kind == KIND_ADV));

  assign mem_en = (state == S_MOD) && mod_done;
  assign mem_we = (item_kind == KIND_LOAD);

  assign roi_commit = (state == S_GEN) && gen_done && (item_kind == KIND_ROI);
  assign roi_bad    = (item_xl > item_xr) || (item_yb > item_yt)
                   || (CMP_W'(item_xr) >= CMP_W'(map_width))
                   || (CMP_W'(item_yt) >= CMP_W'(map_height))
                   || (channel_count == '0)
                   || (CMP_W'(channel_count) > CH_LIMIT)
                   || (gen_raw >= RAW_W'(STORE_WORDS));

  assign emit_fire = (state == S_EMIT) && (!m_tvalid || m_tready);

  rfc_addr_gen #(
    .COORD_BITS (COORD_BITS)
  ) u_addr_gen (
    .clk        (clk),
    .rst        (rst),
    .start      (gen_start),
    .ch         (gen_ch),
    .row        (gen_row),
    .col        (gen_col),
    .map_width  (map_width),
    .map_height (map_height),
    .done       (gen_done),
    .raw        (gen_raw)
  );

  rfc_mod_unit #(
    .STORE_WORDS (STORE_WORDS),
    .RAW_W       (RAW_W)
  ) u_mod_unit (
    .clk   (clk),
    .rst   (rst),
    .start (mod_start),
    .raw   (mod_raw),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  rfc_store #(
    .STORE_WORDS (STORE_WORDS)
  ) u_store (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mod_rem),
    .wdata (item_value),
    .rdata (rd_data)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (in_kind)
            KIND_LOAD: state_next = S_MOD;
            KIND_ROI:  state_next = S_GEN;
            KIND_ADV:  state_next = crop_ok ? S_GEN : S_EMIT;
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_GEN: begin
        if (gen_done) begin
          state_next = (item_kind == KIND_ROI) ? S_IDLE : S_MOD;
        end
      end
      S_MOD: begin
        if (mod_done) begin
          state_next = (item_kind == KIND_LOAD) ? S_IDLE : S_EMIT;
        end
      end
      S_EMIT: begin
        if (emit_fire) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      map_width     <= MAP_WIDTH_RST;
      map_height    <= MAP_HEIGHT_RST;
      channel_count <= CHANNELS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAP_WIDTH:  map_width     <= cfg_data;
        REG_MAP_HEIGHT: map_height    <= cfg_data;
        REG_CHANNELS:   channel_count <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_kind  <= in_kind;
      item_value <= s_tdata[VAL_LSB +: WORD_W];
      item_xl    <= in_xl;
      item_yb    <= in_yb;
      item_xr    <= in_xr;
      item_yt    <= in_yt;
      item_first <= s_tdata[FIRST_LSB];
      priority if (!roi_active) begin
        item_status <= STAT_NO_ROI;
      end else if (roi_rejected) begin
        item_status <= STAT_REJECT;
      end else begin
        item_status <= STAT_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      roi_xl       <= '0;
      roi_yb       <= '0;
      roi_xr       <= '0;
      roi_yt       <= '0;
      ch_cnt       <= '0;
      row_cnt      <= '0;
      col_cnt      <= '0;
      out_idx      <= '0;
      roi_active   <= 1'b0;
      roi_rejected <= 1'b0;
    end else if (roi_commit) begin
      roi_xl       <= item_xl;
      roi_yb       <= item_yb;
      roi_xr       <= item_xr;
      roi_yt       <= item_yt;
      ch_cnt       <= '0;
      row_cnt      <= '0;
      col_cnt      <= '0;
      roi_active   <= 1'b1;
      roi_rejected <= roi_bad;
      if (item_first) begin
        out_idx <= '0;
      end
    end else if (emit_fire && (item_status == STAT_OK)) begin
      out_idx <= out_idx + INDEX_W'(1);
      priority if (adv_last) begin
        roi_active <= 1'b0;
        ch_cnt     <= '0;
        row_cnt    <= '0;
        col_cnt    <= '0;
      end else if (!col_end) begin
        col_cnt <= col_cnt + COORD_BITS'(1);
      end else if (!row_end) begin
        col_cnt <= '0;
        row_cnt <= row_cnt + COORD_BITS'(1);
      end else begin
        col_cnt <= '0;
        row_cnt <= '0;
        ch_cnt  <= ch_cnt + COORD_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_status <= item_status;
      if (item_status == STAT_OK) begin
        out_value <= rd_data;
        out_index <= out_idx;
        out_last  <= adv_last;
      end else begin
        out_value <= '0;
        out_index <= '0;
        out_last  <= 1'b0;
      end
    end
  end

  assign m_tdata = {{OUT_PAD{1'b0}}, out_index, out_value};
  assign m_tuser = out_status;
  assign m_tlast = out_last;

`ifndef SYNTHESIS
  a_gen_done_in_gen: assert property (@(posedge clk) disable iff (rst)
    gen_done |-> (state == S_GEN))
    else $error("address pipeline finished outside its wait state");

  a_mod_done_in_mod: assert property (@(posedge clk) disable iff (rst)
    mod_done |-> (state == S_MOD))
    else $error("address reduction finished outside its wait state");

  a_read_only_when_cropping: assert property (@(posedge clk) disable iff (rst)
    (mem_en && !mem_we) |-> crop_ok)
    else $error("store read without an accepted ROI");

  a_last_ends_roi: assert property (@(posedge clk) disable iff (rst)
    (emit_fire && (item_status == STAT_OK) && adv_last) |=> !roi_active)
    else $error("ROI still active after its last word");

  a_index_steps: assert property (@(posedge clk) disable iff (rst)
    (emit_fire && (item_status == STAT_OK)) |=> (out_idx == $past(out_idx) + INDEX_W'(1)))
    else $error("output index did not advance by one");
`endif

endmodule

// ===== tb/sv/roi_feature_crop_test.sv =====
`timescale 1ns / 1ps

module roi_feature_crop_test;
  import rfc_pkg::*;

  localparam int CW          = COORD_BITS_DEF;
  localparam int S_DATA_W    = (LOAD_ADDR_W+WORD_W+4*COORD_BITS_DEF+1+7)/8*8;
  localparam int M_DATA_W    = (WORD_W+INDEX_W+7)/8*8;
  localparam int ITEM_TARGET = 1950;
  localparam int PHASE_ITEMS = 100;
  localparam int SETTLE      = 24;
  localparam int HOLD_CYCLES = 300;

  // kind and register index with no meaning to the block
  localparam logic [KIND_W-1:0]    KIND_SPARE = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE  = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0]      kind;
    logic [LOAD_ADDR_W-1:0] load_address;
    logic [WORD_W-1:0]      load_value;
    logic [CW-1:0]          x_left;
    logic [CW-1:0]          y_bottom;
    logic [CW-1:0]          x_right;
    logic [CW-1:0]          y_top;
    logic                   first_roi;
  } crop_item_t;

  typedef struct packed {
    logic [WORD_W-1:0]   value;
    logic [INDEX_W-1:0]  dest_index;
    logic                last_of_roi;
    logic [STATUS_W-1:0] status;
  } crop_word_t;

  typedef enum {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_CADENCE} rx_mode_t;

  class crop_scoreboard;
    bit [WORD_W-1:0]  store_words [STORE_WORDS_DEF];
    bit               loaded [STORE_WORDS_DEF];
    bit [CFG_W-1:0]   map_w, map_h, chans;
    bit [CW-1:0]      xl, yb, xr, yt, ch_n, row_n, col_n;
    bit [INDEX_W-1:0] out_idx;
    bit               active, rejected;
    crop_word_t       due [$];
    int               errors;

    function new();
      map_w  = MAP_WIDTH_RST;
      map_h  = MAP_HEIGHT_RST;
      chans  = CHANNELS_RST;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_MAP_WIDTH: map_w = val;
        REG_MAP_HEIGHT: map_h = val;
        REG_CHANNELS: chans = val;
        default: ;
      endcase
    endfunction

    function int unsigned flat_addr(int unsigned ch, int unsigned row, int unsigned col);
      return ch * map_w * map_h + row * map_w + col;
    endfunction

    // store entry the next advance reads, -1 when it reads none
    function int read_addr();
      if (!active || rejected) return -1;
      return flat_addr(ch_n, int'(yb) + int'(row_n), int'(xl) + int'(col_n))
             % STORE_WORDS_DEF;
    endfunction

    function void advance();
      crop_word_t w;
      int         addr;
      bit         col_end, row_end, ch_end;
      w = '0;
      if (!active) begin
        w.status = STAT_NO_ROI;
      end else if (rejected) begin
        w.status = STAT_REJECT;
      end else begin
        addr = read_addr();
        col_end = int'(xl) + int'(col_n) >= int'(xr);
        row_end = int'(yb) + int'(row_n) >= int'(yt);
        ch_end  = int'(ch_n) + 1 >= int'(chans);
        w.value       = store_words[addr];
        w.dest_index  = out_idx;
        w.last_of_roi = col_end && row_end && ch_end;
        w.status      = STAT_OK;
        out_idx++;
        if (w.last_of_roi) begin
          active = 0;
          ch_n = 0;
          row_n = 0;
          col_n = 0;
        end else if (!col_end) begin
          col_n++;
        end else if (!row_end) begin
          col_n = 0;
          row_n++;
        end else begin
          col_n = 0;
          row_n = 0;
          ch_n++;
        end
      end
      due.push_back(w);
    endfunction

    function void note_input(crop_item_t it);
      bit bad;
      case (it.kind)
        KIND_LOAD: begin
          store_words[it.load_address] = it.load_value;
          loaded[it.load_address] = 1;
        end
        KIND_ROI: begin
          bad = it.x_left > it.x_right || it.y_bottom > it.y_top ||
                it.x_right >= map_w || it.y_top >= map_h ||
                chans == 0 || chans > (1 << CW);
          if (!bad && flat_addr(chans - 1, it.y_top, it.x_right) >= STORE_WORDS_DEF)
            bad = 1;
          xl = it.x_left;
          yb = it.y_bottom;
          xr = it.x_right;
          yt = it.y_top;
          ch_n = 0;
          row_n = 0;
          col_n = 0;
          if (it.first_roi) out_idx = 0;
          active = 1;
          rejected = bad;
        end
        KIND_ADV: advance();
        default: ;
      endcase
    endfunction

    task report(string field, logic [63:0] got, logic [63:0] want);
      $display("%0t crop %s: got %0h, want %0h", $time, field, got, want);
      errors++;
    endtask

    task check_result(crop_word_t got);
      crop_word_t want;
      if (due.size() == 0) begin
        report("word with nothing pending", got, 0);
        return;
      end
      want = due.pop_front();
      if (got.value !== want.value) report("value", got.value, want.value);
      if (got.dest_index !== want.dest_index)
        report("dest_index", got.dest_index, want.dest_index);
      if (got.last_of_roi !== want.last_of_roi)
        report("last_of_roi", got.last_of_roi, want.last_of_roi);
      if (got.status !== want.status) report("status", got.status, want.status);
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  // load_address, load_value, x_left, y_bottom, x_right, y_top, first_roi
  logic [S_DATA_W-1:0]  s_tdata = '0;
  // kind
  logic [KIND_W-1:0]    s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  // value, dest_index
  logic [M_DATA_W-1:0]  m_tdata;
  // status
  logic [STATUS_W-1:0]  m_tuser;
  logic                 m_tlast;

  crop_scoreboard sb = new();
  int burst_left = 0;
  int items_sent = 0;
  int hold_trigger = 0;

  int phase_cfg [12][3] = '{
    '{64, 64, 1}, '{1, 1, 64}, '{8, 8, 64}, '{64, 1, 64}, '{1, 64, 64}, '{64, 64, 2},
    '{13, 7, 5}, '{0, 64, 1}, '{64, 0, 1}, '{64, 64, 0}, '{127, 127, 100}, '{64, 64, 1}
  };

  roi_feature_crop dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #12_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // receiver: changing stall patterns, plus long hold-offs on request
  initial begin
    int         hold_seen, hold_left, mode_left, cyc;
    rx_mode_t   mode;
    crop_word_t got;
    hold_seen = 0;
    hold_left = 0;
    mode_left = 0;
    cyc = 0;
    mode = RX_OPEN;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        got = crop_word_t'({m_tdata[WORD_W-1:0], m_tdata[WORD_W+INDEX_W-1:WORD_W],
                            m_tlast, m_tuser});
        sb.check_result(got);
      end
      cyc++;
      if (hold_trigger != hold_seen) begin
        hold_seen = hold_trigger;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(50, 400);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        case (mode)
          RX_OPEN: m_tready <= 1'b1;
          RX_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
          RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= (cyc % 5) < 2;
        endcase
      end
    end
  end

  function automatic crop_item_t random_item(logic [KIND_W-1:0] kind);
    crop_item_t it;
    it.kind = kind;
    it.load_address = LOAD_ADDR_W'($urandom);
    it.load_value = $urandom;
    {it.x_left, it.y_bottom, it.x_right, it.y_top, it.first_roi} = (4*CW+1)'($urandom);
    return it;
  endfunction

  task automatic send_item(input crop_item_t it);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
    end
    s_tvalid <= 1'b1;
    s_tuser <= it.kind;
    s_tdata <= S_DATA_W'({it.first_roi, it.y_top, it.x_right, it.y_bottom, it.x_left,
                          it.load_value, it.load_address});
    do @(posedge clk); while (!s_tready);
    sb.note_input(it);
    burst_left--;
    if (it.kind != KIND_SPARE) items_sent++;
  endtask

  task automatic send_load(input int addr, input logic [WORD_W-1:0] val);
    crop_item_t it;
    it = random_item(KIND_LOAD);
    it.load_address = LOAD_ADDR_W'(addr);
    it.load_value = val;
    send_item(it);
  endtask

  task automatic send_roi(input int x0, input int y0, input int x1, input int y1,
                          input bit first);
    crop_item_t it;
    it = random_item(KIND_ROI);
    it.x_left = CW'(x0);
    it.y_bottom = CW'(y0);
    it.x_right = CW'(x1);
    it.y_top = CW'(y1);
    it.first_roi = first;
    send_item(it);
  endtask

  // loads the word first if the advance would read an empty entry
  task automatic send_advance();
    int a;
    a = sb.read_addr();
    if (a >= 0 && !sb.loaded[a]) send_load(a, $urandom);
    send_item(random_item(KIND_ADV));
  endtask

  task automatic crop_through(input int max_steps);
    int n;
    n = 0;
    while (sb.active && !sb.rejected && n < max_steps) begin
      send_advance();
      n++;
    end
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic program_regs(input int w, input int h, input int c);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= REG_SPARE;
    cfg_data <= CFG_W'($urandom);
    @(posedge clk);
    cfg_index <= REG_MAP_WIDTH;
    cfg_data <= CFG_W'(w);
    @(posedge clk);
    cfg_index <= REG_MAP_HEIGHT;
    cfg_data <= CFG_W'(h);
    @(posedge clk);
    cfg_index <= REG_CHANNELS;
    cfg_data <= CFG_W'(c);
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(REG_MAP_WIDTH, CFG_W'(w));
    sb.set_reg(REG_MAP_HEIGHT, CFG_W'(h));
    sb.set_reg(REG_CHANNELS, CFG_W'(c));
  endtask

  // ROI that fits the current map, about 64 words at most
  task automatic pick_roi(input bit first);
    int w, h, c, span, cols, rows, x0, y0;
    w = (sb.map_w == 0) ? 1 : (sb.map_w > 64) ? 64 : sb.map_w;
    h = (sb.map_h == 0) ? 1 : (sb.map_h > 64) ? 64 : sb.map_h;
    c = sb.chans;
    span = (c <= 1 || c > 64) ? 64 : 64 / c;
    cols = $urandom_range(1, (w < span) ? w : span);
    span = span / cols;
    rows = $urandom_range(1, (h < span) ? h : span);
    x0 = $urandom_range(0, w - cols);
    y0 = $urandom_range(0, h - rows);
    send_roi(x0, y0, x0 + cols - 1, y0 + rows - 1, first);
  endtask

  task automatic random_phase(input int quota);
    int start_n, r;
    start_n = items_sent;
    while (items_sent - start_n < quota) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        pick_roi($urandom_range(0, 3) == 0);
        crop_through(($urandom_range(0, 7) == 0) ? $urandom_range(0, 5) : 1 << 20);
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) send_advance();
      end else if (r < 72) begin
        send_load($urandom_range(0, STORE_WORDS_DEF - 1), $urandom);
      end else if (r < 84) begin
        send_item(random_item(KIND_ROI));
        repeat ($urandom_range(1, 3)) send_advance();
      end else if (r < 94) begin
        send_advance();
      end else begin
        send_item(random_item(KIND_SPARE));
      end
    end
  endtask

  initial begin
    int p;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    program_regs(MAP_WIDTH_RST, MAP_HEIGHT_RST, CHANNELS_RST);

    send_advance();                       // nothing active after reset
    send_item(random_item(KIND_SPARE));
    send_load(0, '0);
    send_load(STORE_WORDS_DEF - 1, '1);
    send_roi(0, 0, 0, 0, 1'b1);
    send_advance();
    send_advance();                       // crop finished
    send_roi(63, 63, 63, 63, 1'b0);       // index keeps counting
    send_advance();
    send_roi(5, 0, 4, 0, 1'b0);           // columns reversed
    send_advance();
    send_roi(0, 5, 0, 4, 1'b1);           // rows reversed
    send_advance();
    // geometry changed in the middle of a crop
    send_roi(0, 0, 1, 1, 1'b1);
    send_advance();
    send_advance();
    program_regs(2, 2, 2);
    crop_through(16);
    // channel count dropped below the channel in progress ends the crop
    program_regs(2, 2, 4);
    send_roi(0, 0, 1, 1, 1'b0);
    crop_through(9);
    program_regs(2, 2, 1);
    crop_through(16);
    program_regs(1, 64, 100);
    send_roi(1, 0, 1, 0, 1'b0);           // beyond map width
    send_advance();
    send_roi(0, 0, 0, 0, 1'b0);           // too many channels
    send_advance();
    program_regs(64, 64, 0);
    send_roi(0, 0, 0, 0, 1'b0);
    send_advance();
    program_regs(64, 64, 2);
    send_roi(63, 63, 63, 63, 1'b0);       // last word past the store
    send_advance();

    p = 0;
    while (items_sent < ITEM_TARGET) begin
      if (p < 12)
        program_regs(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2]);
      else
        program_regs($urandom_range(0, 1) ? $urandom_range(1, 16) : $urandom_range(1, 64),
                     $urandom_range(0, 1) ? $urandom_range(1, 16) : $urandom_range(1, 64),
                     ($urandom_range(0, 3) == 0) ? $urandom_range(1, 64)
                                                 : $urandom_range(1, 4));
      // long receiver hold-off while items keep coming
      if (p == 1 || p == 6) hold_trigger++;
      random_phase(PHASE_ITEMS);
      p++;
    end

    wait_idle();
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
